// File: hdl/ost_pkg.sv
// ost_pkg: shared types and codes for the ordered set table
// request and response word layouts, request and status codes, controller states
// no dependencies
package ost_pkg;

	// request codes
	localparam logic [2:0] REQ_ADD    = 3'd0;
	localparam logic [2:0] REQ_REMOVE = 3'd1;
	localparam logic [2:0] REQ_FIND   = 3'd2;
	localparam logic [2:0] REQ_READ   = 3'd3;
	localparam logic [2:0] REQ_CLEAR  = 3'd4;

	// status codes
	localparam logic [2:0] STATUS_OK       = 3'd0;
	localparam logic [2:0] STATUS_DUP      = 3'd1;
	localparam logic [2:0] STATUS_NOTFOUND = 3'd2;
	localparam logic [2:0] STATUS_RANGE    = 3'd3;
	localparam logic [2:0] STATUS_FULL     = 3'd4;

	typedef struct packed {
		logic [2:0]         req_type;
		logic signed [31:0] item;
		logic [4:0]         position;
	} req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [4:0]         found_position;
		logic signed [31:0] read_value;
		logic [5:0]         entry_count;
		logic               empty_flag;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_SHIFT,
		S_READ,
		S_RESP
	} ost_state_t;

endpackage

// File: hdl/ordered_set_table_unit.sv
// ordered_set_table_unit: insertion-ordered set of signed 32-bit values with compacting delete
// depends on ost_pkg and ost_ram
// entries live in one ost_ram; a small controller walks it one entry per cycle

// The table holds up to CAPACITY distinct values in the order they were added,
// stored in a single ram with one write and one registered read port. One
// request word is worked on at a time and gives exactly one response word.
// Add, remove and find scan the ram from position zero at one entry per cycle
// (read of the next entry overlaps the compare of the previous one); a remove
// then streams the later entries down one place, reading one and writing the
// one before it each cycle. Read, clear and unused codes need no scan, and
// every request ends in S_RESP. The response sits in an output register, so
// a new request is taken while an older response still waits for rsp_ready.
// No clearing pass is needed after reset: only entries below the count are
// ever read.
module ordered_set_table_unit
	import ost_pkg::*;
#(
	parameter int CAPACITY = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	ost_state_t state_q, state_d;

	// request being worked on
	req_t req_q;

	// scan pointer: next ram address to read
	logic [CW-1:0] idx_q, idx_d;
	logic [CW-1:0] count_q, count_d;

	// read in flight: registered copies of the issue flag and the ram address
	logic          rd_vld_s1;
	logic [AW-1:0] rd_addr_s1;
	logic          issue;

	// result fields gathered before the response is loaded
	logic [2:0]  status_q, status_d;
	logic [4:0]  fpos_q, fpos_d;
	logic [31:0] rval_q, rval_d;

	rsp_t rsp_q;
	logic rsp_valid_q;
	logic load_rsp;

	// ram port
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [31:0]   mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic [31:0]   mem_rdata;

	logic hit;
	logic more;

	ost_ram #(
		.WIDTH(32),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// compare of the word read last cycle, and whether entries remain to read
	assign hit  = rd_vld_s1 && (mem_rdata == req_q.item);
	assign more = idx_q < count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		count_d   = count_q;
		status_d  = status_q;
		fpos_d    = fpos_q;
		rval_d    = rval_q;
		mem_we    = 1'b0;
		mem_waddr = rd_addr_s1 - AW'(1);
		mem_wdata = mem_rdata;
		mem_raddr = idx_q[AW-1:0];
		issue     = 1'b0;
		load_rsp  = 1'b0;
		req_ready = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					status_d = STATUS_OK;
					fpos_d   = '0;
					rval_d   = '0;
					idx_d    = '0;
					unique case (req.req_type)
						REQ_ADD, REQ_REMOVE, REQ_FIND: begin
							state_d = S_SEARCH;
						end
						REQ_READ: begin
							// ram read goes out now, data lands in S_READ
							mem_raddr = AW'(req.position);
							if (32'(req.position) >= 32'(count_q)) begin
								status_d = STATUS_RANGE;
								state_d  = S_RESP;
							end else begin
								state_d = S_READ;
							end
						end
						REQ_CLEAR: begin
							count_d = '0;
							state_d = S_RESP;
						end
						default: begin
							state_d = S_RESP;
						end
					endcase
				end
			end
			S_SEARCH: begin
				if (hit) begin
					unique case (req_q.req_type)
						REQ_ADD: begin
							status_d = STATUS_DUP;
							state_d  = S_RESP;
						end
						REQ_REMOVE: begin
							// compact from the entry after the match
							idx_d   = CW'(rd_addr_s1) + CW'(1);
							state_d = S_SHIFT;
						end
						default: begin
							fpos_d  = 5'(rd_addr_s1);
							state_d = S_RESP;
						end
					endcase
				end else if (!more) begin
					// every entry compared, no match
					state_d = S_RESP;
					if (req_q.req_type == REQ_ADD) begin
						if (count_q >= CAP_C) begin
							status_d = STATUS_FULL;
						end else begin
							mem_we    = 1'b1;
							mem_waddr = count_q[AW-1:0];
							mem_wdata = req_q.item;
							count_d   = count_q + CW'(1);
						end
					end else begin
						status_d = STATUS_NOTFOUND;
					end
				end else begin
					issue = 1'b1;
					idx_d = idx_q + CW'(1);
				end
			end
			S_SHIFT: begin
				// word read last cycle moves down one place
				mem_we = rd_vld_s1;
				if (more) begin
					issue = 1'b1;
					idx_d = idx_q + CW'(1);
				end else begin
					count_d = count_q - CW'(1);
					state_d = S_RESP;
				end
			end
			S_READ: begin
				rval_d  = mem_rdata;
				state_d = S_RESP;
			end
			S_RESP: begin
				if (!rsp_valid_q || rsp_ready) begin
					load_rsp = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			idx_q       <= '0;
			rd_vld_s1   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q   <= count_d;
			idx_q     <= idx_d;
			rd_vld_s1 <= issue;
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_q <= req;
		end
		rd_addr_s1 <= mem_raddr;
		status_q   <= status_d;
		fpos_q     <= fpos_d;
		rval_q     <= rval_d;
		if (load_rsp) begin
			rsp_q.status         <= status_q;
			rsp_q.found_position <= fpos_q;
			rsp_q.read_value     <= rval_q;
			rsp_q.entry_count    <= 6'(count_q);
			rsp_q.empty_flag     <= (count_q == '0);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// the count never passes the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C)
		else $error("entry count beyond capacity");

	// every ram write lands at or below the current count
	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (CW'(mem_waddr) <= count_q))
		else $error("ram write beyond the packed region");

	// compaction only runs on a non-empty table
	a_shift_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT) |-> (count_q != '0))
		else $error("compaction with empty table");

	// an accepted request always starts work
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> (state_q != S_IDLE))
		else $error("request accepted but controller stayed idle");

	// a response is only loaded when the output slot is free or draining
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_rsp |-> (!rsp_valid_q || rsp_ready))
		else $error("response overwritten before taken");

endmodule

// File: hdl/ost_ram.sv
// ost_ram: generic simple dual-port ram, one write port and one registered read port
// no dependencies
module ost_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
